### design/assert_macros.svh
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising clock edge out of reset
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle check");

// next-cycle implication, checked on every rising clock edge out of reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle check");

`endif

### design/icsp_pkg.sv
// types and constants of the icsp serial programming master
`default_nettype none

package icsp_pkg;

   // sequencer phases
   typedef enum logic [4:0] {
      PH_IDLE, PH_C_PULSE, PH_C_KEYSET, PH_K_DATA, PH_K_HIGH, PH_K_LOW,
      PH_C_RELEASE, PH_I_HIGH, PH_I_LOW, PH_END, PH_Z_HIGH, PH_Z_LOW,
      PH_X_DATA, PH_X_HIGH, PH_X_LOW, PH_R1_HIGH, PH_R1_LOW, PH_R0_DATA,
      PH_RC_HIGH, PH_RC_LOW, PH_RD_HIGH, PH_RD_LOW, PH_RF_HIGH, PH_RF_LOW,
      PH_R_END, PH_D_END, PH_H_END
   } phase_type;

   // command codes, the remaining codes are ignored
   typedef enum logic [2:0] {
      OP_CONNECT     = 3'd0,
      OP_SIX         = 3'd1,
      OP_REGOUT      = 3'd2,
      OP_DISCONNECT  = 3'd3,
      OP_RESET_PULSE = 3'd4
   } op_type;

   // configuration register indexes
   typedef enum logic [2:0] {
      CSR_HALF_PERIOD     = 3'd0,
      CSR_ENTRY_KEY       = 3'd1,
      CSR_RESET_SETUP     = 3'd2,
      CSR_RESET_PULSE     = 3'd3,
      CSR_KEY_SETUP       = 3'd4,
      CSR_ENTRY_WAIT      = 3'd5,
      CSR_HARD_RESET      = 3'd6,
      CSR_DISCONNECT_WAIT = 3'd7
   } csr_index_type;

   // which delay register loads the tick counter
   typedef enum logic [2:0] {
      DLY_HALF, DLY_RESET_SETUP, DLY_RESET_PULSE, DLY_KEY_SETUP,
      DLY_ENTRY_WAIT, DLY_HARD_RESET, DLY_DISCONNECT
   } dly_type;

   localparam int DELAY_WIDTH = 24;

   // bit and clock counts of the sequences
   localparam logic [5:0] KEY_BITS     = 6'd32;
   localparam logic [5:0] IDLE_CLOCKS  = 6'd33;
   localparam logic [5:0] SIX_BITS     = 6'd24;
   localparam logic [5:0] ZERO_CLOCKS  = 6'd4;
   localparam logic [5:0] REGOUT_LEAD  = 6'd10;
   localparam logic [5:0] READ_BITS    = 6'd16;

   typedef struct packed {
      logic [7:0]             half_period;
      logic [31:0]            entry_key;
      logic [DELAY_WIDTH-1:0] reset_setup_ticks;
      logic [DELAY_WIDTH-1:0] reset_pulse_ticks;
      logic [DELAY_WIDTH-1:0] key_setup_ticks;
      logic [DELAY_WIDTH-1:0] entry_wait_ticks;
      logic [DELAY_WIDTH-1:0] hard_reset_ticks;
      logic [DELAY_WIDTH-1:0] disconnect_wait_ticks;
   } cfg_type;

   typedef struct packed {
      logic mclr;
      logic pgd_drive;
      logic pgd_out;
      logic pgc;
   } pins_type;

   typedef struct packed {
      pins_type    pins;
      logic        busy;
      logic        read_valid;
      logic [15:0] read_data;
   } status_type;

endpackage

`default_nettype wire

### design/icsp_seq.sv
// pin sequencer: one tick of the command state machine per step
`default_nettype none

module icsp_seq #(
   parameter int COUNT_WIDTH = 24
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step,
   input  wire logic                 cmd_valid,
   input  wire logic [2:0]           op,
   input  wire logic [23:0]          instr,
   input  wire logic                 pgd_in,
   input  wire icsp_pkg::cfg_type    cfg,
   output icsp_pkg::status_type      status
);

   localparam int DW = icsp_pkg::DELAY_WIDTH;

   icsp_pkg::phase_type   phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0] wait_ff, wait_in, arm_val;
   logic [5:0]            bit_ff, bit_in, bit_inc;
   logic [31:0]           shift_ff, shift_in;
   logic [15:0]           rdsh_ff, rdsh_in;
   icsp_pkg::pins_type    pins_ff, pins_in;
   logic                  arm_en, rv;
   icsp_pkg::dly_type     dly_sel;
   logic [DW-1:0]         dly_raw, dly_min;
   logic                  is_idle, do_act;
   logic [4:0]            rd_idx;

   assign is_idle = (phase_ff == icsp_pkg::PH_IDLE);
   assign do_act  = !is_idle && (wait_ff == '0);
   assign bit_inc = bit_ff + 6'd1;
   assign rd_idx  = {1'b0, bit_ff[3:0]};

   // next phase and which delay to load
   always_comb begin
      phase_in = phase_ff;
      arm_en   = 1'b0;
      dly_sel  = icsp_pkg::DLY_HALF;
      if (is_idle) begin
         if (cmd_valid) begin
            unique case (icsp_pkg::op_type'(op))
               icsp_pkg::OP_CONNECT: begin
                  phase_in = icsp_pkg::PH_C_PULSE;
                  arm_en   = 1'b1;
                  dly_sel  = icsp_pkg::DLY_RESET_SETUP;
               end
               icsp_pkg::OP_SIX: begin
                  phase_in = icsp_pkg::PH_Z_LOW;
                  arm_en   = 1'b1;
               end
               icsp_pkg::OP_REGOUT: begin
                  phase_in = icsp_pkg::PH_R1_HIGH;
                  arm_en   = 1'b1;
               end
               icsp_pkg::OP_DISCONNECT: begin
                  phase_in = icsp_pkg::PH_D_END;
                  arm_en   = 1'b1;
                  dly_sel  = icsp_pkg::DLY_DISCONNECT;
               end
               icsp_pkg::OP_RESET_PULSE: begin
                  phase_in = icsp_pkg::PH_H_END;
                  arm_en   = 1'b1;
                  dly_sel  = icsp_pkg::DLY_HARD_RESET;
               end
               default: ;
            endcase
         end
      end else if (do_act) begin
         arm_en = 1'b1;
         unique case (phase_ff)
            icsp_pkg::PH_C_PULSE: begin
               phase_in = icsp_pkg::PH_C_KEYSET;
               dly_sel  = icsp_pkg::DLY_RESET_PULSE;
            end
            icsp_pkg::PH_C_KEYSET: begin
               phase_in = icsp_pkg::PH_K_DATA;
               dly_sel  = icsp_pkg::DLY_KEY_SETUP;
            end
            icsp_pkg::PH_K_DATA:  phase_in = icsp_pkg::PH_K_HIGH;
            icsp_pkg::PH_K_HIGH:  phase_in = icsp_pkg::PH_K_LOW;
            icsp_pkg::PH_K_LOW:
               phase_in = (bit_inc >= icsp_pkg::KEY_BITS) ? icsp_pkg::PH_C_RELEASE
                                                          : icsp_pkg::PH_K_DATA;
            icsp_pkg::PH_C_RELEASE: begin
               phase_in = icsp_pkg::PH_I_HIGH;
               dly_sel  = icsp_pkg::DLY_ENTRY_WAIT;
            end
            icsp_pkg::PH_I_HIGH:  phase_in = icsp_pkg::PH_I_LOW;
            icsp_pkg::PH_I_LOW:
               phase_in = (bit_inc >= icsp_pkg::IDLE_CLOCKS) ? icsp_pkg::PH_END
                                                             : icsp_pkg::PH_I_HIGH;
            icsp_pkg::PH_Z_HIGH:  phase_in = icsp_pkg::PH_Z_LOW;
            icsp_pkg::PH_Z_LOW:
               phase_in = (bit_inc >= icsp_pkg::ZERO_CLOCKS) ? icsp_pkg::PH_X_DATA
                                                             : icsp_pkg::PH_Z_HIGH;
            icsp_pkg::PH_X_DATA:  phase_in = icsp_pkg::PH_X_HIGH;
            icsp_pkg::PH_X_HIGH:  phase_in = icsp_pkg::PH_X_LOW;
            icsp_pkg::PH_X_LOW:
               phase_in = (bit_inc >= icsp_pkg::SIX_BITS) ? icsp_pkg::PH_END
                                                          : icsp_pkg::PH_X_DATA;
            icsp_pkg::PH_R1_HIGH: phase_in = icsp_pkg::PH_R1_LOW;
            icsp_pkg::PH_R1_LOW:  phase_in = icsp_pkg::PH_R0_DATA;
            icsp_pkg::PH_R0_DATA: phase_in = icsp_pkg::PH_RC_HIGH;
            icsp_pkg::PH_RC_HIGH: phase_in = icsp_pkg::PH_RC_LOW;
            icsp_pkg::PH_RC_LOW:
               phase_in = (bit_inc >= icsp_pkg::REGOUT_LEAD) ? icsp_pkg::PH_RD_HIGH
                                                             : icsp_pkg::PH_RC_HIGH;
            icsp_pkg::PH_RD_HIGH: phase_in = icsp_pkg::PH_RD_LOW;
            icsp_pkg::PH_RD_LOW:
               phase_in = (bit_inc >= icsp_pkg::READ_BITS) ? icsp_pkg::PH_RF_HIGH
                                                           : icsp_pkg::PH_RD_HIGH;
            icsp_pkg::PH_RF_HIGH: phase_in = icsp_pkg::PH_RF_LOW;
            icsp_pkg::PH_RF_LOW:  phase_in = icsp_pkg::PH_R_END;
            default: begin
               // end phases and unused codes fall back to idle
               phase_in = icsp_pkg::PH_IDLE;
               arm_en   = 1'b0;
            end
         endcase
      end
   end

   // pins, counters and shift registers
   always_comb begin
      pins_in  = pins_ff;
      bit_in   = bit_ff;
      shift_in = shift_ff;
      rdsh_in  = rdsh_ff;
      rv       = 1'b0;
      if (is_idle) begin
         if (cmd_valid) begin
            unique case (icsp_pkg::op_type'(op))
               icsp_pkg::OP_CONNECT: begin
                  bit_in            = '0;
                  pins_in.pgc       = 1'b0;
                  pins_in.pgd_out   = 1'b0;
                  pins_in.pgd_drive = 1'b1;
                  pins_in.mclr      = 1'b0;
               end
               icsp_pkg::OP_SIX: begin
                  bit_in            = '0;
                  shift_in          = {8'd0, instr};
                  pins_in.pgd_drive = 1'b1;
                  pins_in.pgd_out   = 1'b0;
                  pins_in.pgc       = 1'b1;
               end
               icsp_pkg::OP_REGOUT: begin
                  bit_in            = '0;
                  shift_in          = '0;
                  pins_in.pgc       = 1'b0;
                  pins_in.pgd_drive = 1'b1;
                  pins_in.pgd_out   = 1'b1;
               end
               icsp_pkg::OP_DISCONNECT: begin
                  bit_in            = '0;
                  pins_in.pgd_drive = 1'b1;
                  pins_in.pgd_out   = 1'b0;
                  pins_in.pgc       = 1'b0;
               end
               icsp_pkg::OP_RESET_PULSE: begin
                  bit_in       = '0;
                  pins_in.mclr = 1'b0;
               end
               default: ;
            endcase
         end
      end else if (do_act) begin
         unique case (phase_ff)
            icsp_pkg::PH_C_PULSE: pins_in.mclr = 1'b1;
            icsp_pkg::PH_C_KEYSET: begin
               pins_in.mclr = 1'b0;
               shift_in     = cfg.entry_key;
               bit_in       = '0;
            end
            icsp_pkg::PH_K_DATA, icsp_pkg::PH_X_DATA: begin
               pins_in.pgd_drive = 1'b1;
               pins_in.pgd_out   = shift_ff[0];
            end
            icsp_pkg::PH_K_LOW, icsp_pkg::PH_X_LOW: begin
               pins_in.pgc = 1'b0;
               shift_in    = {1'b0, shift_ff[31:1]};
               bit_in      = bit_inc;
            end
            icsp_pkg::PH_C_RELEASE: begin
               pins_in.pgd_out   = 1'b0;
               pins_in.pgd_drive = 1'b0;
               pins_in.mclr      = 1'b1;
               bit_in            = '0;
            end
            icsp_pkg::PH_I_HIGH: begin
               pins_in.pgd_drive = 1'b1;
               pins_in.pgd_out   = 1'b0;
               pins_in.pgc       = 1'b1;
            end
            icsp_pkg::PH_I_LOW: begin
               pins_in.pgc = 1'b0;
               bit_in      = bit_inc;
            end
            icsp_pkg::PH_END: begin
               pins_in.pgd_out   = 1'b0;
               pins_in.pgd_drive = 1'b0;
            end
            icsp_pkg::PH_K_HIGH, icsp_pkg::PH_Z_HIGH, icsp_pkg::PH_X_HIGH,
            icsp_pkg::PH_R1_HIGH, icsp_pkg::PH_RC_HIGH, icsp_pkg::PH_RF_HIGH:
               pins_in.pgc = 1'b1;
            icsp_pkg::PH_Z_LOW: begin
               pins_in.pgc = 1'b0;
               bit_in = (bit_inc >= icsp_pkg::ZERO_CLOCKS) ? 6'd0 : bit_inc;
            end
            icsp_pkg::PH_R1_LOW, icsp_pkg::PH_RF_LOW: pins_in.pgc = 1'b0;
            icsp_pkg::PH_R0_DATA: begin
               pins_in.pgd_out = 1'b0;
               bit_in          = '0;
            end
            icsp_pkg::PH_RC_LOW: begin
               pins_in.pgc = 1'b0;
               bit_in = (bit_inc >= icsp_pkg::REGOUT_LEAD) ? 6'd0 : bit_inc;
            end
            icsp_pkg::PH_RD_HIGH: begin
               pins_in.pgd_drive = 1'b0;
               pins_in.pgc       = 1'b1;
            end
            icsp_pkg::PH_RD_LOW: begin
               // sample the data pin on the falling clock edge, lsb first
               pins_in.pgc      = 1'b0;
               shift_in[rd_idx] = shift_ff[rd_idx] | pgd_in;
               bit_in           = bit_inc;
            end
            icsp_pkg::PH_R_END: begin
               rdsh_in = shift_ff[15:0];
               rv      = 1'b1;
            end
            icsp_pkg::PH_D_END: pins_in.mclr = 1'b0;
            icsp_pkg::PH_H_END: pins_in.mclr = 1'b1;
            default: ;
         endcase
      end
   end

   // delay select, zero counts as one tick
   always_comb begin
      unique case (dly_sel)
         icsp_pkg::DLY_HALF:        dly_raw = {{(DW-8){1'b0}}, cfg.half_period};
         icsp_pkg::DLY_RESET_SETUP: dly_raw = cfg.reset_setup_ticks;
         icsp_pkg::DLY_RESET_PULSE: dly_raw = cfg.reset_pulse_ticks;
         icsp_pkg::DLY_KEY_SETUP:   dly_raw = cfg.key_setup_ticks;
         icsp_pkg::DLY_ENTRY_WAIT:  dly_raw = cfg.entry_wait_ticks;
         icsp_pkg::DLY_HARD_RESET:  dly_raw = cfg.hard_reset_ticks;
         icsp_pkg::DLY_DISCONNECT:  dly_raw = cfg.disconnect_wait_ticks;
         default:                   dly_raw = '0;
      endcase
      dly_min = (dly_raw == '0) ? DW'(1) : dly_raw;
   end

   // counter load value, saturating at the counter width
   generate
      if (COUNT_WIDTH >= DW) begin : g_wide
         assign arm_val = COUNT_WIDTH'(dly_min) - COUNT_WIDTH'(1);
      end else begin : g_narrow
         assign arm_val = (|dly_min[DW-1:COUNT_WIDTH])
                        ? ({COUNT_WIDTH{1'b1}} - COUNT_WIDTH'(1))
                        : (dly_min[COUNT_WIDTH-1:0] - COUNT_WIDTH'(1));
      end
   endgenerate

   // tick counter
   always_comb begin
      if (arm_en) begin
         wait_in = arm_val;
      end else if (!is_idle && (wait_ff != '0)) begin
         wait_in = wait_ff - COUNT_WIDTH'(1);
      end else begin
         wait_in = wait_ff;
      end
   end

   // state registers, advanced once per accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= icsp_pkg::PH_IDLE;
         wait_ff  <= '0;
         bit_ff   <= '0;
         shift_ff <= '0;
         rdsh_ff  <= '0;
         pins_ff  <= '{mclr: 1'b1, pgd_drive: 1'b1, pgd_out: 1'b0, pgc: 1'b0};
      end else if (step) begin
         phase_ff <= phase_in;
         wait_ff  <= wait_in;
         bit_ff   <= bit_in;
         shift_ff <= shift_in;
         rdsh_ff  <= rdsh_in;
         pins_ff  <= pins_in;
      end
   end

   // result of this tick
   assign status.pins       = pins_in;
   assign status.busy       = (phase_in != icsp_pkg::PH_IDLE);
   assign status.read_valid = rv;
   assign status.read_data  = rdsh_in;

endmodule

`default_nettype wire

### design/icsp_serial_programming_master_core.sv
// top level of the icsp serial programming master
//
// channel  direction  carries
// req      in         one timebase tick: command, instruction, sampled data pin
// rsp      out        pin levels, busy, read strobe and read data after the tick
// csr      in         register writes, index 0 to 7
//
// one item per cycle while rsp takes every result: each accepted tick updates the
// sequencer and lands in the result register on the same edge.
// req_tready follows rsp_tready while a result is held; the result register
// parts the two sides, and a stall on rsp holds the sequencer where it stands.
// reset (synchronous) returns the registers to their default values, mclr high,
// data driven low, and empties the result register.
`default_nettype none

`include "assert_macros.svh"

module icsp_serial_programming_master_core #(
   parameter int COUNT_WIDTH = 24
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // ticks in
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [31:0] req_tdata,   // instruction[23:0], pgd_in[24], zero
   input  wire logic [3:0]  req_tuser,   // command_valid[0], operation[3:1]
   // results out
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // pgc[0], pgd_out[1], pgd_drive[2], mclr[3], busy_res[4], read_valid[5],
   // read_data[21:6], zero
   output      logic [23:0] rsp_tdata,
   // register writes
   input  wire logic        csr_wr_en,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);

   localparam int DW = icsp_pkg::DELAY_WIDTH;

   icsp_pkg::cfg_type    cfg_ff;
   icsp_pkg::status_type status;
   logic                 rsp_valid_ff;
   logic [23:0]          rsp_data_ff;
   logic                 accept;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.half_period           <= 8'd10;
         cfg_ff.entry_key             <= 32'd0;
         cfg_ff.reset_setup_ticks     <= DW'(3000);
         cfg_ff.reset_pulse_ticks     <= DW'(200);
         cfg_ff.key_setup_ticks       <= DW'(10);
         cfg_ff.entry_wait_ticks      <= DW'(25000);
         cfg_ff.hard_reset_ticks      <= DW'(20000);
         cfg_ff.disconnect_wait_ticks <= DW'(10000);
      end else if (csr_wr_en) begin
         unique case (icsp_pkg::csr_index_type'(csr_index))
            icsp_pkg::CSR_HALF_PERIOD:     cfg_ff.half_period <= csr_wdata[7:0];
            icsp_pkg::CSR_ENTRY_KEY:       cfg_ff.entry_key <= csr_wdata;
            icsp_pkg::CSR_RESET_SETUP:     cfg_ff.reset_setup_ticks <= csr_wdata[DW-1:0];
            icsp_pkg::CSR_RESET_PULSE:     cfg_ff.reset_pulse_ticks <= csr_wdata[DW-1:0];
            icsp_pkg::CSR_KEY_SETUP:       cfg_ff.key_setup_ticks <= csr_wdata[DW-1:0];
            icsp_pkg::CSR_ENTRY_WAIT:      cfg_ff.entry_wait_ticks <= csr_wdata[DW-1:0];
            icsp_pkg::CSR_HARD_RESET:      cfg_ff.hard_reset_ticks <= csr_wdata[DW-1:0];
            icsp_pkg::CSR_DISCONNECT_WAIT:
               cfg_ff.disconnect_wait_ticks <= csr_wdata[DW-1:0];
            default: ;
         endcase
      end
   end

   // pin sequencer
   icsp_seq #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .step      (accept),
      .cmd_valid (req_tuser[0]),
      .op        (req_tuser[3:1]),
      .instr     (req_tdata[23:0]),
      .pgd_in    (req_tdata[24]),
      .cfg       (cfg_ff),
      .status    (status)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= {2'b00, status.read_data, status.read_valid, status.busy,
                         status.pins.mclr, status.pins.pgd_drive,
                         status.pins.pgd_out, status.pins.pgc};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // a held result blocks new ticks
   `ASSERT_SAME(a_stall_blocks, clock, reset, rsp_valid_ff && !rsp_tready, !req_tready)
   // every accepted tick yields a result on the next cycle
   `ASSERT_NEXT(a_accept_result, clock, reset, accept, rsp_valid_ff)
   // a finished read leaves the data pin released and the block idle
   `ASSERT_SAME(a_read_end, clock, reset, rsp_valid_ff && rsp_data_ff[5],
                !rsp_data_ff[2] && !rsp_data_ff[4])

endmodule

`default_nettype wire

### test/testbench.sv
// testbench of the icsp programming master: random tick stream checked against a cycle model
module testbench;

   // one timebase tick as offered to the block
   typedef struct packed {
      logic        cmd_valid;
      logic [2:0]  op;
      logic [23:0] instr;
      logic        pgd_in;
   } tick_item_type;

   // pin and status levels after one tick
   typedef struct packed {
      logic        pgc;
      logic        pgd_out;
      logic        pgd_drive;
      logic        mclr;
      logic        busy;
      logic        read_valid;
      logic [15:0] read_data;
   } tick_result_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // instruction[23:0], pgd_in[24], zero
   logic [3:0]  req_tuser;   // command_valid[0], operation[3:1]
   logic        rsp_tvalid;
   logic        rsp_tready;
   // pgc[0], pgd_out[1], pgd_drive[2], mclr[3], busy_res[4], read_valid[5], read_data[21:6]
   logic [23:0] rsp_tdata;
   logic        csr_wr_en;
   logic [2:0]  csr_index;
   logic [31:0] csr_wdata;

   icsp_serial_programming_master_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // sequencer model state and register copy
   icsp_pkg::phase_type seq_phase;
   logic [23:0]         seq_wait;
   logic [5:0]          seq_bits;
   logic [31:0]         seq_shift;
   logic [15:0]         seq_read;
   icsp_pkg::pins_type  seq_pins;
   icsp_pkg::cfg_type   regs;

   tick_result_type result_queue[$];
   int              mismatches;
   int              burst_left;

   // load the tick counter: zero acts as one, long delays clip to the counter range
   function automatic void schedule(input logic [31:0] delay,
                                    input icsp_pkg::phase_type nxt);
      logic [31:0] d;
      d = (delay == 32'd0) ? 32'd1 : delay;
      if (d > 32'h00FF_FFFF) d = 32'h00FF_FFFF;
      seq_wait = 24'(d - 32'd1);
      seq_phase = nxt;
   endfunction

   // advance the sequencer by one tick and return the pin levels after it
   function automatic tick_result_type predict_tick(input tick_item_type it);
      tick_result_type r;
      logic            strobe;
      logic [31:0]     hp;
      strobe = 1'b0;
      hp = 32'(regs.half_period);
      if (seq_phase == icsp_pkg::PH_IDLE) begin
         if (it.cmd_valid && it.op <= icsp_pkg::OP_RESET_PULSE) begin
            seq_bits = 6'd0;
            case (icsp_pkg::op_type'(it.op))
               icsp_pkg::OP_CONNECT: begin
                  seq_pins.pgc = 1'b0; seq_pins.pgd_out = 1'b0;
                  seq_pins.pgd_drive = 1'b1; seq_pins.mclr = 1'b0;
                  schedule(32'(regs.reset_setup_ticks), icsp_pkg::PH_C_PULSE);
               end
               icsp_pkg::OP_SIX: begin
                  seq_shift = 32'(it.instr);
                  seq_pins.pgd_drive = 1'b1; seq_pins.pgd_out = 1'b0; seq_pins.pgc = 1'b1;
                  schedule(hp, icsp_pkg::PH_Z_LOW);
               end
               icsp_pkg::OP_REGOUT: begin
                  seq_shift = 32'd0;
                  seq_pins.pgc = 1'b0; seq_pins.pgd_drive = 1'b1; seq_pins.pgd_out = 1'b1;
                  schedule(hp, icsp_pkg::PH_R1_HIGH);
               end
               icsp_pkg::OP_DISCONNECT: begin
                  seq_pins.pgd_drive = 1'b1; seq_pins.pgd_out = 1'b0; seq_pins.pgc = 1'b0;
                  schedule(32'(regs.disconnect_wait_ticks), icsp_pkg::PH_D_END);
               end
               default: begin
                  seq_pins.mclr = 1'b0;
                  schedule(32'(regs.hard_reset_ticks), icsp_pkg::PH_H_END);
               end
            endcase
         end
      end else if (seq_wait != 24'd0) begin
         seq_wait = seq_wait - 24'd1;
      end else begin
         case (seq_phase)
            // connect: entry pulse on mclr
            icsp_pkg::PH_C_PULSE: begin
               seq_pins.mclr = 1'b1;
               schedule(32'(regs.reset_pulse_ticks), icsp_pkg::PH_C_KEYSET);
            end
            icsp_pkg::PH_C_KEYSET: begin
               seq_pins.mclr = 1'b0; seq_shift = regs.entry_key; seq_bits = 6'd0;
               schedule(32'(regs.key_setup_ticks), icsp_pkg::PH_K_DATA);
            end
            // connect: 32 key bits, lsb first
            icsp_pkg::PH_K_DATA: begin
               seq_pins.pgd_drive = 1'b1; seq_pins.pgd_out = seq_shift[0];
               schedule(hp, icsp_pkg::PH_K_HIGH);
            end
            icsp_pkg::PH_K_HIGH: begin
               seq_pins.pgc = 1'b1;
               schedule(hp, icsp_pkg::PH_K_LOW);
            end
            icsp_pkg::PH_K_LOW: begin
               seq_pins.pgc = 1'b0; seq_shift = seq_shift >> 1; seq_bits = seq_bits + 6'd1;
               schedule(hp, (seq_bits >= 6'd32) ? icsp_pkg::PH_C_RELEASE
                                                : icsp_pkg::PH_K_DATA);
            end
            // connect: release and 33 idle clocks
            icsp_pkg::PH_C_RELEASE: begin
               seq_pins.pgd_out = 1'b0; seq_pins.pgd_drive = 1'b0; seq_pins.mclr = 1'b1;
               seq_bits = 6'd0;
               schedule(32'(regs.entry_wait_ticks), icsp_pkg::PH_I_HIGH);
            end
            icsp_pkg::PH_I_HIGH: begin
               seq_pins.pgd_drive = 1'b1; seq_pins.pgd_out = 1'b0; seq_pins.pgc = 1'b1;
               schedule(hp, icsp_pkg::PH_I_LOW);
            end
            icsp_pkg::PH_I_LOW: begin
               seq_pins.pgc = 1'b0; seq_bits = seq_bits + 6'd1;
               schedule(hp, (seq_bits >= 6'd33) ? icsp_pkg::PH_END : icsp_pkg::PH_I_HIGH);
            end
            icsp_pkg::PH_END: begin
               seq_pins.pgd_out = 1'b0; seq_pins.pgd_drive = 1'b0;
               seq_phase = icsp_pkg::PH_IDLE;
            end
            // six: four zero clocks, then 24 instruction bits
            icsp_pkg::PH_Z_HIGH: begin
               seq_pins.pgc = 1'b1;
               schedule(hp, icsp_pkg::PH_Z_LOW);
            end
            icsp_pkg::PH_Z_LOW: begin
               seq_pins.pgc = 1'b0; seq_bits = seq_bits + 6'd1;
               if (seq_bits >= 6'd4) begin
                  seq_bits = 6'd0;
                  schedule(hp, icsp_pkg::PH_X_DATA);
               end else begin
                  schedule(hp, icsp_pkg::PH_Z_HIGH);
               end
            end
            icsp_pkg::PH_X_DATA: begin
               seq_pins.pgd_drive = 1'b1; seq_pins.pgd_out = seq_shift[0];
               schedule(hp, icsp_pkg::PH_X_HIGH);
            end
            icsp_pkg::PH_X_HIGH: begin
               seq_pins.pgc = 1'b1;
               schedule(hp, icsp_pkg::PH_X_LOW);
            end
            icsp_pkg::PH_X_LOW: begin
               seq_pins.pgc = 1'b0; seq_shift = seq_shift >> 1; seq_bits = seq_bits + 6'd1;
               schedule(hp, (seq_bits >= 6'd24) ? icsp_pkg::PH_END : icsp_pkg::PH_X_DATA);
            end
            // regout: command bits 1,0,0,0 and seven idle clocks
            icsp_pkg::PH_R1_HIGH: begin
               seq_pins.pgc = 1'b1;
               schedule(hp, icsp_pkg::PH_R1_LOW);
            end
            icsp_pkg::PH_R1_LOW: begin
               seq_pins.pgc = 1'b0;
               schedule(hp, icsp_pkg::PH_R0_DATA);
            end
            icsp_pkg::PH_R0_DATA: begin
               seq_pins.pgd_out = 1'b0; seq_bits = 6'd0;
               schedule(hp, icsp_pkg::PH_RC_HIGH);
            end
            icsp_pkg::PH_RC_HIGH: begin
               seq_pins.pgc = 1'b1;
               schedule(hp, icsp_pkg::PH_RC_LOW);
            end
            icsp_pkg::PH_RC_LOW: begin
               seq_pins.pgc = 1'b0; seq_bits = seq_bits + 6'd1;
               if (seq_bits >= 6'd10) begin
                  seq_bits = 6'd0;
                  schedule(hp, icsp_pkg::PH_RD_HIGH);
               end else begin
                  schedule(hp, icsp_pkg::PH_RC_HIGH);
               end
            end
            // regout: 16 bits sampled on the falling edges
            icsp_pkg::PH_RD_HIGH: begin
               seq_pins.pgd_drive = 1'b0; seq_pins.pgc = 1'b1;
               schedule(hp, icsp_pkg::PH_RD_LOW);
            end
            icsp_pkg::PH_RD_LOW: begin
               seq_pins.pgc = 1'b0;
               if (it.pgd_in) seq_shift[seq_bits[3:0]] = 1'b1;
               seq_bits = seq_bits + 6'd1;
               schedule(hp, (seq_bits >= 6'd16) ? icsp_pkg::PH_RF_HIGH
                                                : icsp_pkg::PH_RD_HIGH);
            end
            icsp_pkg::PH_RF_HIGH: begin
               seq_pins.pgc = 1'b1;
               schedule(hp, icsp_pkg::PH_RF_LOW);
            end
            icsp_pkg::PH_RF_LOW: begin
               seq_pins.pgc = 1'b0;
               schedule(hp, icsp_pkg::PH_R_END);
            end
            icsp_pkg::PH_R_END: begin
               seq_read = seq_shift[15:0]; strobe = 1'b1;
               seq_phase = icsp_pkg::PH_IDLE;
            end
            icsp_pkg::PH_D_END: begin
               seq_pins.mclr = 1'b0;
               seq_phase = icsp_pkg::PH_IDLE;
            end
            icsp_pkg::PH_H_END: begin
               seq_pins.mclr = 1'b1;
               seq_phase = icsp_pkg::PH_IDLE;
            end
            default: seq_phase = icsp_pkg::PH_IDLE;
         endcase
      end
      r.pgc = seq_pins.pgc;
      r.pgd_out = seq_pins.pgd_out;
      r.pgd_drive = seq_pins.pgd_drive;
      r.mclr = seq_pins.mclr;
      r.busy = (seq_phase != icsp_pkg::PH_IDLE);
      r.read_valid = strobe;
      r.read_data = seq_read;
      return r;
   endfunction

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // result side: full-rate stretches and rotating stall patterns
   initial begin
      int         run;
      logic [7:0] pat;
      run = 0;
      pat = 8'hFF;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (run == 0) begin
            run = $urandom_range(8, 160);
            pat = ($urandom_range(0, 2) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
         end
         run--;
         rsp_tready <= pat[0];
         pat = {pat[0], pat[7:1]};
      end
   end

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h got %0h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // results are checked on the falling clock edge ahead of the edge that takes them,
   // when every handshake signal has settled
   always @(negedge clock) begin
      tick_result_type want;
      tick_result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.pgc = rsp_tdata[0];
         got.pgd_out = rsp_tdata[1];
         got.pgd_drive = rsp_tdata[2];
         got.mclr = rsp_tdata[3];
         got.busy = rsp_tdata[4];
         got.read_valid = rsp_tdata[5];
         got.read_data = rsp_tdata[21:6];
         if (result_queue.size() == 0) begin
            $display("%0t: unexpected item expected none got %h", $time, rsp_tdata);
            mismatches++;
         end else begin
            want = result_queue.pop_front();
            check_field("pgc", 16'(want.pgc), 16'(got.pgc));
            check_field("pgd_out", 16'(want.pgd_out), 16'(got.pgd_out));
            check_field("pgd_drive", 16'(want.pgd_drive), 16'(got.pgd_drive));
            check_field("mclr", 16'(want.mclr), 16'(got.mclr));
            check_field("busy", 16'(want.busy), 16'(got.busy));
            check_field("read_valid", 16'(want.read_valid), 16'(got.read_valid));
            check_field("read_data", want.read_data, got.read_data);
         end
      end
   end

   function automatic tick_item_type make_tick(input logic cmd, input logic [2:0] op,
                                               input logic [23:0] instr);
      tick_item_type t;
      t.cmd_valid = cmd;
      t.op = op;
      t.instr = instr;
      t.pgd_in = 1'($urandom_range(0, 1));
      return t;
   endfunction

   function automatic logic [23:0] random_instr();
      case ($urandom_range(0, 7))
         0: return 24'hFF_FFFF;
         1: return 24'h00_0000;
         default: return 24'($urandom);
      endcase
   endfunction

   // send one tick in bursts with random gaps, predict it once taken
   task automatic send_tick(input tick_item_type it);
      int gap;
      if (burst_left == 0) begin
         gap = 0;
         if ($urandom_range(0, 7) == 0) begin
            burst_left = $urandom_range(60, 150);
         end else begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 1) == 1) gap = $urandom_range(1, 4);
         end
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= {7'd0, it.pgd_in, it.instr};
      req_tuser <= {it.op, it.cmd_valid};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      result_queue.push_back(predict_tick(it));
   endtask

   // finish the running command, then drain every result
   task automatic settle();
      while (seq_phase != icsp_pkg::PH_IDLE)
         send_tick(make_tick(1'b0, 3'($urandom_range(0, 7)), random_instr()));
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (result_queue.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // write all eight registers, upper bits of raw words are don't-care
   task automatic load_registers(input logic [7:0][31:0] raw);
      for (int i = 0; i < 8; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= icsp_pkg::csr_index_type'(i);
         csr_wdata <= raw[i];
         @(posedge clock);
         case (icsp_pkg::csr_index_type'(i))
            icsp_pkg::CSR_HALF_PERIOD: regs.half_period = raw[i][7:0];
            icsp_pkg::CSR_ENTRY_KEY:   regs.entry_key = raw[i];
            icsp_pkg::CSR_RESET_SETUP: regs.reset_setup_ticks = raw[i][23:0];
            icsp_pkg::CSR_RESET_PULSE: regs.reset_pulse_ticks = raw[i][23:0];
            icsp_pkg::CSR_KEY_SETUP:   regs.key_setup_ticks = raw[i][23:0];
            icsp_pkg::CSR_ENTRY_WAIT:  regs.entry_wait_ticks = raw[i][23:0];
            icsp_pkg::CSR_HARD_RESET:  regs.hard_reset_ticks = raw[i][23:0];
            default:                   regs.disconnect_wait_ticks = raw[i][23:0];
         endcase
      end
      csr_wr_en <= 1'b0;
   endtask

   // issue one command and run it to the end, offering junk commands meanwhile
   task automatic run_command(input logic [2:0] op, input logic [23:0] instr);
      send_tick(make_tick(1'b1, op, instr));
      while (seq_phase != icsp_pkg::PH_IDLE)
         send_tick(make_tick(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                             random_instr()));
   endtask

   // pin levels left by reset, idle ticks and unknown codes are ignored
   task automatic test_reset_defaults();
      for (int i = 0; i < 3; i++)
         send_tick(make_tick(1'b0, 3'($urandom_range(0, 7)), random_instr()));
      send_tick(make_tick(1'b1, 3'd5, random_instr()));
      send_tick(make_tick(1'b1, 3'd6, random_instr()));
      send_tick(make_tick(1'b1, 3'd7, random_instr()));
      settle();
   endtask

   // zero half period and zero delays that act as one tick, mixed key, unknown codes
   task automatic test_fast_extremes();
      logic [7:0][31:0] raw;
      raw[icsp_pkg::CSR_HALF_PERIOD]     = 32'h1234_5600;
      raw[icsp_pkg::CSR_ENTRY_KEY]       = 32'hC3A5_0FF1;
      raw[icsp_pkg::CSR_RESET_SETUP]     = 32'hFF00_0000;
      raw[icsp_pkg::CSR_RESET_PULSE]     = 32'h0000_0000;
      raw[icsp_pkg::CSR_KEY_SETUP]       = 32'hA500_0000;
      raw[icsp_pkg::CSR_ENTRY_WAIT]      = 32'h0000_0000;
      raw[icsp_pkg::CSR_HARD_RESET]      = 32'h8000_0000;
      raw[icsp_pkg::CSR_DISCONNECT_WAIT] = 32'h0000_0000;
      load_registers(raw);
      run_command(icsp_pkg::OP_CONNECT, 24'h00_0000);
      run_command(icsp_pkg::OP_SIX, 24'hFF_FFFF);
      run_command(icsp_pkg::OP_DISCONNECT, 24'h00_0000);
      run_command(icsp_pkg::OP_RESET_PULSE, 24'h00_0000);
      run_command(3'd5, 24'h12_3456);
      run_command(3'd6, 24'h00_0000);
      run_command(3'd7, 24'hFF_FFFF);
      settle();
   endtask

   // commands on every tick: one on the tick that ends the previous is dropped
   task automatic test_back_to_back();
      for (int i = 0; i < 8; i++)
         send_tick(make_tick(1'b1, (i % 4 < 2) ? icsp_pkg::OP_DISCONNECT
                                               : icsp_pkg::OP_RESET_PULSE,
                             random_instr()));
      settle();
   endtask

   // counted waits: two ticks per half period, longer disconnect and reset pulse
   task automatic test_slow_delays();
      logic [7:0][31:0] raw;
      raw[icsp_pkg::CSR_HALF_PERIOD]     = 32'hABCD_EF02;
      raw[icsp_pkg::CSR_ENTRY_KEY]       = 32'h0000_0000;
      raw[icsp_pkg::CSR_RESET_SETUP]     = 32'hFFFF_FFFF;
      raw[icsp_pkg::CSR_RESET_PULSE]     = 32'h00FF_FFFF;
      raw[icsp_pkg::CSR_KEY_SETUP]       = 32'h00FF_FFFF;
      raw[icsp_pkg::CSR_ENTRY_WAIT]      = 32'hFFFF_FFFF;
      raw[icsp_pkg::CSR_HARD_RESET]      = 32'h5A00_0007;
      raw[icsp_pkg::CSR_DISCONNECT_WAIT] = 32'h0000_0005;
      load_registers(raw);
      run_command(icsp_pkg::OP_REGOUT, 24'h00_0000);
      run_command(icsp_pkg::OP_DISCONNECT, 24'h00_0000);
      run_command(icsp_pkg::OP_RESET_PULSE, 24'h00_0000);
      settle();
   endtask

   // random short commands and junk under a random register setting
   task automatic test_random_traffic();
      logic [7:0][31:0] raw;
      logic             cmd;
      logic [2:0]       op;
      raw[icsp_pkg::CSR_HALF_PERIOD] = {24'($urandom), 8'($urandom_range(0, 3))};
      raw[icsp_pkg::CSR_ENTRY_KEY]   = $urandom;
      for (int i = 2; i < 8; i++)
         raw[i] = {8'($urandom), 24'($urandom_range(0, 4))};
      load_registers(raw);
      for (int n = 0; n < 50; n++) begin
         if (seq_phase == icsp_pkg::PH_IDLE) begin
            cmd = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 3))
               0:       op = 3'($urandom_range(5, 7));
               1:       op = icsp_pkg::OP_DISCONNECT;
               default: op = icsp_pkg::OP_RESET_PULSE;
            endcase
         end else begin
            cmd = 1'($urandom_range(0, 1));
            op = 3'($urandom_range(0, 7));
         end
         send_tick(make_tick(cmd, op, random_instr()));
      end
      settle();
   endtask

   // reset, tests in turn, final verdict
   initial begin
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= 32'd0;
      req_tuser <= 4'd0;
      csr_wr_en <= 1'b0;
      csr_index <= icsp_pkg::CSR_HALF_PERIOD;
      csr_wdata <= 32'd0;
      mismatches = 0;
      burst_left = 0;
      regs.half_period = 8'd10;
      regs.entry_key = 32'd0;
      regs.reset_setup_ticks = 24'd3000;
      regs.reset_pulse_ticks = 24'd200;
      regs.key_setup_ticks = 24'd10;
      regs.entry_wait_ticks = 24'd25000;
      regs.hard_reset_ticks = 24'd20000;
      regs.disconnect_wait_ticks = 24'd10000;
      seq_phase = icsp_pkg::PH_IDLE;
      seq_wait = 24'd0;
      seq_bits = 6'd0;
      seq_shift = 32'd0;
      seq_read = 16'd0;
      seq_pins.mclr = 1'b1;
      seq_pins.pgd_drive = 1'b1;
      seq_pins.pgd_out = 1'b0;
      seq_pins.pgc = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_fast_extremes();
      test_back_to_back();
      test_slow_delays();
      test_random_traffic();
      settle();
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // run limit
   initial begin
      #400_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
